[sv/mrs_pkg.sv]
`default_nettype none
package mrs_pkg;

    localparam int IN_SIZE_DEF    = 80;
    localparam int HIDDEN_ONE_DEF = 128;
    localparam int HIDDEN_TWO_DEF = 64;
    localparam int OUT_SIZE_DEF   = 8;

    localparam int ACC_W = 40;
    localparam int E_W   = 17;

    typedef enum logic [1:0] {
        CMD_WEIGHT  = 2'd0,
        CMD_FEATURE = 2'd1,
        CMD_RUN     = 2'd2,
        CMD_RSVD    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        LAYER_ONE = 2'd0,
        LAYER_TWO = 2'd1,
        LAYER_OUT = 2'd2
    } layer_t;

    typedef struct packed {
        logic   load;
        logic   first;
        layer_t layer;
        logic   mac_issue;
        logic   wb;
        logic   max_issue;
        logic   exp_issue;
        logic   div_load;
        logic   out_load;
        logic   out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic mac_idle;
        logic max_idle;
        logic exp_idle;
        logic div_busy;
        logic out_free;
    } dp_stat_t;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // exp(-k/16) in Q16, k = 0..16
    function automatic logic [16:0] exp_frac(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd61565;
            5'd2:    v = 17'd57835;
            5'd3:    v = 17'd54331;
            5'd4:    v = 17'd51039;
            5'd5:    v = 17'd47947;
            5'd6:    v = 17'd45042;
            5'd7:    v = 17'd42313;
            5'd8:    v = 17'd39750;
            5'd9:    v = 17'd37341;
            5'd10:   v = 17'd35079;
            5'd11:   v = 17'd32954;
            5'd12:   v = 17'd30957;
            5'd13:   v = 17'd29081;
            5'd14:   v = 17'd27319;
            5'd15:   v = 17'd25664;
            5'd16:   v = 17'd24109;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-ip) in Q16, ip = 0..11
    function automatic logic [16:0] exp_int(input logic [3:0] ip);
        logic [16:0] v;
        case (ip)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[sv/mrs_if.sv]
`default_nettype none
interface mrs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [14:0]        addr;
    logic signed [15:0] value;

    modport source (output valid, output cmd, output addr, output value, input ready);
    modport sink   (input valid, input cmd, input addr, input value, output ready);
endinterface

interface mrs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  class_index;
    logic [15:0] probability;
    logic        last;

    modport source (output valid, output class_index, output probability, output last,
                    input ready);
    modport sink   (input valid, input class_index, input probability, input last,
                    output ready);
endinterface
`default_nettype wire

[sv/mrs_ram.sv]
`default_nettype none
module mrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [mrs_pkg::addr_w(DEPTH)-1:0]      waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [mrs_pkg::addr_w(DEPTH)-1:0]      raddr,
    output      logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[sv/mrs_datapath.sv]
`default_nettype none
module mrs_datapath #(
    parameter int IN_SIZE    = mrs_pkg::IN_SIZE_DEF,
    parameter int HIDDEN_ONE = mrs_pkg::HIDDEN_ONE_DEF,
    parameter int HIDDEN_TWO = mrs_pkg::HIDDEN_TWO_DEF,
    parameter int OUT_SIZE   = mrs_pkg::OUT_SIZE_DEF,
    localparam int STORE_DEPTH = HIDDEN_ONE * IN_SIZE + HIDDEN_ONE
                               + HIDDEN_TWO * HIDDEN_ONE + HIDDEN_TWO
                               + OUT_SIZE * HIDDEN_TWO + OUT_SIZE,
    localparam int WA_W  = mrs_pkg::addr_w(STORE_DEPTH),
    localparam int MAX_A = (IN_SIZE > HIDDEN_ONE) ? IN_SIZE : HIDDEN_ONE,
    localparam int MAX_B = (HIDDEN_TWO > OUT_SIZE) ? HIDDEN_TWO : OUT_SIZE,
    localparam int IDX_W = mrs_pkg::addr_w((MAX_A > MAX_B) ? MAX_A : MAX_B)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mrs_pkg::dp_cmd_t   cmd,
    output      mrs_pkg::dp_stat_t  stat,
    input  wire logic [WA_W-1:0]    w_addr,
    input  wire logic [IDX_W-1:0]   x_addr,
    input  wire logic [IDX_W-1:0]   n_addr,
    input  wire logic [IDX_W-1:0]   c_addr,
    input  wire logic [1:0]         ld_cmd,
    input  wire logic [14:0]        ld_addr,
    input  wire logic signed [15:0] ld_value,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic [2:0]         class_index,
    output      logic [15:0]        probability,
    output      logic               last
);
    localparam int FA_W  = mrs_pkg::addr_w(IN_SIZE);
    localparam int H1_W  = mrs_pkg::addr_w(HIDDEN_ONE);
    localparam int H2_W  = mrs_pkg::addr_w(HIDDEN_TWO);
    localparam int CA_W  = mrs_pkg::addr_w(OUT_SIZE);
    localparam int SUM_W = mrs_pkg::E_W + CA_W;
    localparam int NUM_W = SUM_W + 17;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int ACC_W = mrs_pkg::ACC_W;

    // loads
    logic [31:0] ld_addr_ext;
    logic        w_we;
    logic        f_we;

    assign ld_addr_ext = 32'(ld_addr);
    assign w_we = cmd.load && (mrs_pkg::cmd_t'(ld_cmd) == mrs_pkg::CMD_WEIGHT)
               && (ld_addr_ext < 32'(STORE_DEPTH));
    assign f_we = cmd.load && (mrs_pkg::cmd_t'(ld_cmd) == mrs_pkg::CMD_FEATURE)
               && (ld_addr_ext < 32'(IN_SIZE));

    logic signed [15:0] w_rd;
    logic signed [15:0] f_rd;
    logic signed [15:0] h1_rd;
    logic signed [15:0] h2_rd;
    logic signed [31:0] l_rd;
    logic [16:0]        e_rd;
    logic [15:0]        hid_val;
    logic [31:0]        logit_val;
    logic               e_we;
    logic [CA_W-1:0]    e_waddr;
    logic [16:0]        e_wdata;

    mrs_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_wram (
        .clk(clk), .we(w_we), .waddr(ld_addr_ext[WA_W-1:0]), .wdata(ld_value),
        .raddr(w_addr), .rdata(w_rd)
    );

    mrs_ram #(.WIDTH(16), .DEPTH(IN_SIZE)) u_fram (
        .clk(clk), .we(f_we), .waddr(ld_addr_ext[FA_W-1:0]), .wdata(ld_value),
        .raddr(x_addr[FA_W-1:0]), .rdata(f_rd)
    );

    mrs_ram #(.WIDTH(16), .DEPTH(HIDDEN_ONE)) u_h1ram (
        .clk(clk), .we(cmd.wb && (cmd.layer == mrs_pkg::LAYER_ONE)),
        .waddr(n_addr[H1_W-1:0]), .wdata(hid_val),
        .raddr(x_addr[H1_W-1:0]), .rdata(h1_rd)
    );

    mrs_ram #(.WIDTH(16), .DEPTH(HIDDEN_TWO)) u_h2ram (
        .clk(clk), .we(cmd.wb && (cmd.layer == mrs_pkg::LAYER_TWO)),
        .waddr(n_addr[H2_W-1:0]), .wdata(hid_val),
        .raddr(x_addr[H2_W-1:0]), .rdata(h2_rd)
    );

    mrs_ram #(.WIDTH(32), .DEPTH(OUT_SIZE)) u_lram (
        .clk(clk), .we(cmd.wb && (cmd.layer == mrs_pkg::LAYER_OUT)),
        .waddr(n_addr[CA_W-1:0]), .wdata(logit_val),
        .raddr(c_addr[CA_W-1:0]), .rdata(l_rd)
    );

    mrs_ram #(.WIDTH(17), .DEPTH(OUT_SIZE)) u_eram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(c_addr[CA_W-1:0]), .rdata(e_rd)
    );

    // MAC pipeline
    logic                    mac_v1_reg, mac_v2_reg;
    logic                    mac_first1_reg, mac_first2_reg;
    logic signed [31:0]      prod2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0]      x_mux;
    logic signed [15:0]      mul_b;
    logic signed [31:0]      prod;
    logic [ACC_W:0]          acc_sum;
    logic [ACC_W-1:0]        acc_next;
    logic [ACC_W:0]          rnd_sum;
    logic [28:0]             rnd;

    always_comb
    begin
        case (cmd.layer)
            mrs_pkg::LAYER_ONE: x_mux = f_rd;
            mrs_pkg::LAYER_TWO: x_mux = h1_rd;
            default:            x_mux = h2_rd;
        endcase
        mul_b = mac_first1_reg ? 16'sd4096 : x_mux;
        prod  = w_rd * mul_b;
        acc_sum = {acc_reg[ACC_W-1], acc_reg} + {{(ACC_W-31){prod2_reg[31]}}, prod2_reg};
        if (mac_first2_reg)
        begin
            acc_next = {{(ACC_W-32){prod2_reg[31]}}, prod2_reg};
        end
        else if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = acc_sum[ACC_W-1:0];
        end
        rnd_sum = {acc_reg[ACC_W-1], acc_reg} + (ACC_W+1)'(2048);
        rnd     = rnd_sum[ACC_W:12];
        if (rnd[28])
        begin
            hid_val = 16'd0;
        end
        else if (|rnd[27:15])
        begin
            hid_val = 16'd32767;
        end
        else
        begin
            hid_val = rnd[15:0];
        end
        logit_val = {{3{rnd[28]}}, rnd};
    end

    // max search
    logic               max_v1_reg, max_first1_reg;
    logic signed [31:0] mx_reg;

    // exp pipeline
    logic             ex_v1_reg, ex_v2_reg, ex_v3_reg;
    logic             ex_f1_reg, ex_f2_reg, ex_f3_reg;
    logic [CA_W-1:0]  ex_i1_reg, ex_i2_reg, ex_i3_reg;
    logic [16:0]      f2_reg;
    logic [3:0]       ip2_reg;
    logic             zero2_reg;
    logic [16:0]      e3_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [32:0]      nval;
    logic [16:0]      fa, fb, fdiff;
    logic [24:0]      fprod;
    logic [16:0]      fval;
    logic [33:0]      eprod;

    always_comb
    begin
        nval  = {mx_reg[31], mx_reg} - {l_rd[31], l_rd};
        fa    = mrs_pkg::exp_frac({1'b0, nval[11:8]});
        fb    = mrs_pkg::exp_frac({1'b0, nval[11:8]} + 5'd1);
        fdiff = fa - fb;
        fprod = 25'(fdiff) * 25'(nval[7:0]) + 25'd128;
        fval  = fa - fprod[24:8];
        eprod = 34'(mrs_pkg::exp_int(ip2_reg)) * 34'(f2_reg) + 34'd32768;
    end

    assign e_we    = ex_v3_reg;
    assign e_waddr = ex_i3_reg;
    assign e_wdata = e3_reg;

    // divider
    logic             div_busy_reg;
    logic [CNT_W-1:0] div_cnt_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [SUM_W:0]   trial;
    logic             ge;
    logic [SUM_W:0]   trial_sub;

    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        ge        = trial >= {1'b0, sum_reg};
        trial_sub = trial - {1'b0, sum_reg};
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_v1_reg   <= 1'b0;
            mac_v2_reg   <= 1'b0;
            max_v1_reg   <= 1'b0;
            ex_v1_reg    <= 1'b0;
            ex_v2_reg    <= 1'b0;
            ex_v3_reg    <= 1'b0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            out_valid    <= 1'b0;
        end
        else
        begin
            mac_v1_reg <= cmd.mac_issue;
            mac_v2_reg <= mac_v1_reg;
            max_v1_reg <= cmd.max_issue;
            ex_v1_reg  <= cmd.exp_issue;
            ex_v2_reg  <= ex_v1_reg;
            ex_v3_reg  <= ex_v2_reg;
            if (cmd.div_load)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg  <= div_cnt_reg - 1'b1;
                div_busy_reg <= (div_cnt_reg != CNT_W'(1));
            end
            if (cmd.out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mac_first1_reg <= cmd.first;
        mac_first2_reg <= mac_first1_reg;
        prod2_reg      <= prod;
        if (mac_v2_reg)
        begin
            acc_reg <= acc_next;
        end

        max_first1_reg <= cmd.first;
        if (max_v1_reg && (max_first1_reg || (l_rd > mx_reg)))
        begin
            mx_reg <= l_rd;
        end

        ex_f1_reg <= cmd.first;
        ex_f2_reg <= ex_f1_reg;
        ex_f3_reg <= ex_f2_reg;
        ex_i1_reg <= c_addr[CA_W-1:0];
        ex_i2_reg <= ex_i1_reg;
        ex_i3_reg <= ex_i2_reg;
        f2_reg    <= fval;
        ip2_reg   <= nval[15:12];
        zero2_reg <= (|nval[32:16]) || (nval[15:12] >= 4'd12);
        e3_reg    <= zero2_reg ? 17'd0 : eprod[32:16];
        if (ex_v3_reg)
        begin
            sum_reg <= ex_f3_reg ? SUM_W'(e3_reg) : sum_reg + SUM_W'(e3_reg);
        end

        if (cmd.div_load)
        begin
            rem_reg <= '0;
            num_reg <= {{(NUM_W - 33){1'b0}}, e_rd, 16'd0}
                     + {{(NUM_W - SUM_W + 1){1'b0}}, sum_reg[SUM_W-1:1]};
            quo_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            rem_reg <= ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end

        if (cmd.out_load)
        begin
            class_index <= 3'(c_addr);
            probability <= (|quo_reg[NUM_W-1:16]) ? 16'hFFFF : quo_reg[15:0];
            last        <= cmd.out_last;
        end
    end

    assign stat.mac_idle = !mac_v1_reg && !mac_v2_reg;
    assign stat.max_idle = !max_v1_reg;
    assign stat.exp_idle = !ex_v1_reg && !ex_v2_reg && !ex_v3_reg;
    assign stat.div_busy = div_busy_reg;
    assign stat.out_free = !out_valid || out_ready;
endmodule
`default_nettype wire

[sv/mrs_ctrl.sv]
`default_nettype none
module mrs_ctrl #(
    parameter int IN_SIZE    = mrs_pkg::IN_SIZE_DEF,
    parameter int HIDDEN_ONE = mrs_pkg::HIDDEN_ONE_DEF,
    parameter int HIDDEN_TWO = mrs_pkg::HIDDEN_TWO_DEF,
    parameter int OUT_SIZE   = mrs_pkg::OUT_SIZE_DEF,
    localparam int STORE_DEPTH = HIDDEN_ONE * IN_SIZE + HIDDEN_ONE
                               + HIDDEN_TWO * HIDDEN_ONE + HIDDEN_TWO
                               + OUT_SIZE * HIDDEN_TWO + OUT_SIZE,
    localparam int WA_W  = mrs_pkg::addr_w(STORE_DEPTH),
    localparam int MAX_A = (IN_SIZE > HIDDEN_ONE) ? IN_SIZE : HIDDEN_ONE,
    localparam int MAX_B = (HIDDEN_TWO > OUT_SIZE) ? HIDDEN_TWO : OUT_SIZE,
    localparam int IDX_W = mrs_pkg::addr_w((MAX_A > MAX_B) ? MAX_A : MAX_B)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [1:0]        in_cmd,
    output      logic              in_ready,
    output      mrs_pkg::dp_cmd_t  cmd,
    input  wire mrs_pkg::dp_stat_t stat,
    output      logic [WA_W-1:0]   w_addr,
    output      logic [IDX_W-1:0]  x_addr,
    output      logic [IDX_W-1:0]  n_addr,
    output      logic [IDX_W-1:0]  c_addr
);
    localparam int OFS_B1 = HIDDEN_ONE * IN_SIZE;
    localparam int OFS_W2 = OFS_B1 + HIDDEN_ONE;
    localparam int OFS_B2 = OFS_W2 + HIDDEN_TWO * HIDDEN_ONE;
    localparam int OFS_W3 = OFS_B2 + HIDDEN_TWO;
    localparam int OFS_B3 = OFS_W3 + OUT_SIZE * HIDDEN_TWO;

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_MAC       = 13'b0000000000010,
        ST_MAC_DRAIN = 13'b0000000000100,
        ST_WB        = 13'b0000000001000,
        ST_MAX       = 13'b0000000010000,
        ST_MAX_DRAIN = 13'b0000000100000,
        ST_EXP       = 13'b0000001000000,
        ST_EXP_DRAIN = 13'b0000010000000,
        ST_DIV_RD    = 13'b0000100000000,
        ST_DIV_LOAD  = 13'b0001000000000,
        ST_DIV_WAIT  = 13'b0010000000000,
        ST_EMIT      = 13'b0100000000000,
        ST_SPARE     = 13'b1000000000000
    } state_t;

    state_t           state_reg, state_next;
    mrs_pkg::layer_t  layer_reg, layer_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic             first_reg, first_next;
    logic [WA_W-1:0]  wp_reg, wp_next;

    logic [IDX_W-1:0] j_last;
    logic [IDX_W-1:0] n_last;
    logic [WA_W-1:0]  b_base;
    logic             c_end;

    always_comb
    begin
        case (layer_reg)
            mrs_pkg::LAYER_ONE:
            begin
                j_last = IDX_W'(IN_SIZE - 1);
                n_last = IDX_W'(HIDDEN_ONE - 1);
                b_base = WA_W'(OFS_B1);
            end
            mrs_pkg::LAYER_TWO:
            begin
                j_last = IDX_W'(HIDDEN_ONE - 1);
                n_last = IDX_W'(HIDDEN_TWO - 1);
                b_base = WA_W'(OFS_B2);
            end
            default:
            begin
                j_last = IDX_W'(HIDDEN_TWO - 1);
                n_last = IDX_W'(OUT_SIZE - 1);
                b_base = WA_W'(OFS_B3);
            end
        endcase
        c_end = (c_reg == IDX_W'(OUT_SIZE - 1));
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign w_addr   = first_reg ? (b_base + WA_W'(n_reg)) : wp_reg;
    assign x_addr   = j_reg;
    assign n_addr   = n_reg;
    assign c_addr   = c_reg;

    always_comb
    begin
        state_next = state_reg;
        layer_next = layer_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        c_next     = c_reg;
        first_next = first_reg;
        wp_next    = wp_reg;
        cmd        = '0;
        cmd.layer  = layer_reg;
        cmd.first  = first_reg;
        cmd.out_last = c_end;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid && (mrs_pkg::cmd_t'(in_cmd) == mrs_pkg::CMD_RUN))
                begin
                    layer_next = mrs_pkg::LAYER_ONE;
                    j_next     = '0;
                    n_next     = '0;
                    first_next = 1'b1;
                    wp_next    = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                first_next    = 1'b0;
                if (!first_reg)
                begin
                    wp_next = wp_reg + 1'b1;
                    if (j_reg == j_last)
                    begin
                        j_next     = '0;
                        state_next = ST_MAC_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            ST_MAC_DRAIN:
            begin
                if (stat.mac_idle)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                cmd.wb     = 1'b1;
                first_next = 1'b1;
                if (n_reg != n_last)
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = ST_MAC;
                end
                else
                begin
                    n_next = '0;
                    case (layer_reg)
                        mrs_pkg::LAYER_ONE:
                        begin
                            layer_next = mrs_pkg::LAYER_TWO;
                            wp_next    = WA_W'(OFS_W2);
                            state_next = ST_MAC;
                        end
                        mrs_pkg::LAYER_TWO:
                        begin
                            layer_next = mrs_pkg::LAYER_OUT;
                            wp_next    = WA_W'(OFS_W3);
                            state_next = ST_MAC;
                        end
                        default:
                        begin
                            c_next     = '0;
                            state_next = ST_MAX;
                        end
                    endcase
                end
            end
            ST_MAX:
            begin
                cmd.max_issue = 1'b1;
                first_next    = 1'b0;
                if (c_end)
                begin
                    c_next     = '0;
                    state_next = ST_MAX_DRAIN;
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            ST_MAX_DRAIN:
            begin
                first_next = 1'b1;
                if (stat.max_idle)
                begin
                    state_next = ST_EXP;
                end
            end
            ST_EXP:
            begin
                cmd.exp_issue = 1'b1;
                first_next    = 1'b0;
                if (c_end)
                begin
                    c_next     = '0;
                    state_next = ST_EXP_DRAIN;
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            ST_EXP_DRAIN:
            begin
                if (stat.exp_idle)
                begin
                    state_next = ST_DIV_RD;
                end
            end
            ST_DIV_RD:
            begin
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (c_end)
                    begin
                        c_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        c_next     = c_reg + 1'b1;
                        state_next = ST_DIV_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            layer_reg <= mrs_pkg::LAYER_ONE;
            j_reg     <= '0;
            n_reg     <= '0;
            c_reg     <= '0;
            first_reg <= 1'b0;
            wp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            c_reg     <= c_next;
            first_reg <= first_next;
            wp_reg    <= wp_next;
        end
    end
endmodule
`default_nettype wire

[sv/mlp_relu_softmax_inference.sv]
`default_nettype none
// Three-layer dense network (IN_SIZE -> HIDDEN_ONE -> HIDDEN_TWO -> OUT_SIZE, ReLU, softmax).
// Load beats (weight word, feature value) are taken whenever the block is idle. A run beat
// works through the three layers on the single shared multiply-accumulate, then runs the max
// and exp passes and a bit-serial divider per class (NUM_W = 37 by default); no new beat is
// taken until the last result is loaded.
// Results come out one per class, class 0 first, the last one marked.
module mlp_relu_softmax_inference #(
    parameter int IN_SIZE    = mrs_pkg::IN_SIZE_DEF,
    parameter int HIDDEN_ONE = mrs_pkg::HIDDEN_ONE_DEF,
    parameter int HIDDEN_TWO = mrs_pkg::HIDDEN_TWO_DEF,
    parameter int OUT_SIZE   = mrs_pkg::OUT_SIZE_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mrs_in_if.sink      item,
    mrs_out_if.source   result
);
    localparam int STORE_DEPTH = HIDDEN_ONE * IN_SIZE + HIDDEN_ONE
                               + HIDDEN_TWO * HIDDEN_ONE + HIDDEN_TWO
                               + OUT_SIZE * HIDDEN_TWO + OUT_SIZE;
    localparam int WA_W  = mrs_pkg::addr_w(STORE_DEPTH);
    localparam int MAX_A = (IN_SIZE > HIDDEN_ONE) ? IN_SIZE : HIDDEN_ONE;
    localparam int MAX_B = (HIDDEN_TWO > OUT_SIZE) ? HIDDEN_TWO : OUT_SIZE;
    localparam int IDX_W = mrs_pkg::addr_w((MAX_A > MAX_B) ? MAX_A : MAX_B);

    mrs_pkg::dp_cmd_t  cmd;
    mrs_pkg::dp_stat_t stat;
    logic [WA_W-1:0]   w_addr;
    logic [IDX_W-1:0]  x_addr;
    logic [IDX_W-1:0]  n_addr;
    logic [IDX_W-1:0]  c_addr;

    mrs_ctrl #(
        .IN_SIZE(IN_SIZE), .HIDDEN_ONE(HIDDEN_ONE),
        .HIDDEN_TWO(HIDDEN_TWO), .OUT_SIZE(OUT_SIZE)
    ) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(item.valid), .in_cmd(item.cmd), .in_ready(item.ready),
        .cmd(cmd), .stat(stat),
        .w_addr(w_addr), .x_addr(x_addr), .n_addr(n_addr), .c_addr(c_addr)
    );

    mrs_datapath #(
        .IN_SIZE(IN_SIZE), .HIDDEN_ONE(HIDDEN_ONE),
        .HIDDEN_TWO(HIDDEN_TWO), .OUT_SIZE(OUT_SIZE)
    ) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cmd(cmd), .stat(stat),
        .w_addr(w_addr), .x_addr(x_addr), .n_addr(n_addr), .c_addr(c_addr),
        .ld_cmd(item.cmd), .ld_addr(item.addr), .ld_value(item.value),
        .out_valid(result.valid), .out_ready(result.ready),
        .class_index(result.class_index), .probability(result.probability),
        .last(result.last)
    );
endmodule
`default_nettype wire

[bench/mlp_relu_softmax_inference_test.sv]
`timescale 1ns / 1ps
module mlp_relu_softmax_inference_test;

    localparam int NI = mrs_pkg::IN_SIZE_DEF;
    localparam int NH1 = mrs_pkg::HIDDEN_ONE_DEF;
    localparam int NH2 = mrs_pkg::HIDDEN_TWO_DEF;
    localparam int NO = mrs_pkg::OUT_SIZE_DEF;
    localparam int OFS_B1 = NH1 * NI;
    localparam int OFS_W2 = OFS_B1 + NH1;
    localparam int OFS_B2 = OFS_W2 + NH2 * NH1;
    localparam int OFS_W3 = OFS_B2 + NH2;
    localparam int OFS_B3 = OFS_W3 + NO * NH2;
    localparam int DEPTH = OFS_B3 + NO;
    localparam longint ACC_HI = 64'sd549755813887;
    localparam longint ACC_LO = -64'sd549755813888;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [2:0]  class_index;
        logic [15:0] probability;
        logic        last;
    } prob_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #1 clk = ~clk;

    mrs_in_if  item_if();
    mrs_out_if res_if();

    mlp_relu_softmax_inference u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (res_if)
    );

    shortint weights [DEPTH];
    shortint features [NI];
    prob_t   prob_q [$];
    int      send_idle_pct;
    int      recv_stall_pct;
    int      errors = 0;
    int      quiet_cycles = 0;

    always @(posedge clk)
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic longint sat_acc(input longint a);
        if (a > ACC_HI)
            return ACC_HI;
        if (a < ACC_LO)
            return ACC_LO;
        return a;
    endfunction

    function automatic longint round_q12(input longint acc);
        return (acc + 2048) >>> 12;
    endfunction

    function automatic shortint relu_q12(input longint acc);
        longint v;
        v = round_q12(acc);
        if (v > 32767)
            v = 32767;
        if (v < 0)
            v = 0;
        return shortint'(v);
    endfunction

    function automatic int unsigned exp_neg_q16(input longint n);
        int unsigned ip, k, r, fk, fk1, f;
        int unsigned ftab [17] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
                                   39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664,
                                   24109};
        int unsigned itab [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
        if ((n >> 12) >= 12)
            return 0;
        ip = int'(n >> 12);
        k  = int'((n >> 8) & 15);
        r  = int'(n & 255);
        fk = ftab[k];
        fk1 = ftab[k + 1];
        f  = fk - (((fk - fk1) * r + 128) >> 8);
        return int'((longint'(itab[ip]) * f + 32768) >> 16);
    endfunction

    // full forward pass over the mirrored stores, queues eight probabilities
    task automatic predict_inference();
        shortint h1 [NH1];
        shortint h2 [NH2];
        longint  logit [NO];
        int unsigned e [NO];
        longint acc, mx, sum, p;
        prob_t r;
        for (int i = 0; i < NH1; i++)
        begin
            acc = longint'(weights[OFS_B1 + i]) * 4096;
            for (int j = 0; j < NI; j++)
                acc = sat_acc(acc + longint'(weights[i * NI + j]) * longint'(features[j]));
            h1[i] = relu_q12(acc);
        end
        for (int i = 0; i < NH2; i++)
        begin
            acc = longint'(weights[OFS_B2 + i]) * 4096;
            for (int j = 0; j < NH1; j++)
                acc = sat_acc(acc + longint'(weights[OFS_W2 + i * NH1 + j]) * longint'(h1[j]));
            h2[i] = relu_q12(acc);
        end
        for (int i = 0; i < NO; i++)
        begin
            acc = longint'(weights[OFS_B3 + i]) * 4096;
            for (int j = 0; j < NH2; j++)
                acc = sat_acc(acc + longint'(weights[OFS_W3 + i * NH2 + j]) * longint'(h2[j]));
            logit[i] = round_q12(acc);
        end
        mx = logit[0];
        for (int i = 1; i < NO; i++)
            if (logit[i] > mx)
                mx = logit[i];
        sum = 0;
        for (int i = 0; i < NO; i++)
        begin
            e[i] = exp_neg_q16(mx - logit[i]);
            sum += e[i];
        end
        for (int i = 0; i < NO; i++)
        begin
            p = (longint'(e[i]) * 65536 + sum / 2) / sum;
            if (p > 65535)
                p = 65535;
            r.class_index = i[2:0];
            r.probability = p[15:0];
            r.last = (i == NO - 1);
            prob_q.insert(prob_q.size(), r);
        end
    endtask

    task automatic send_beat(input mrs_pkg::cmd_t c, input int a, input int v);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.cmd   <= c;
        item_if.addr  <= a[14:0];
        item_if.value <= v[15:0];
        do
            @(negedge clk);
        while (!item_if.ready);
        @(posedge clk);
        case (c)
            mrs_pkg::CMD_WEIGHT:  if (a < DEPTH) weights[a] = shortint'(v);
            mrs_pkg::CMD_FEATURE: if (a < NI) features[a] = shortint'(v);
            mrs_pkg::CMD_RUN:     predict_inference();
            default:              ;
        endcase
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (prob_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic run_small_rand(input int lo, input int hi, input int first, input int n);
        for (int a = first; a < first + n; a++)
            send_beat(mrs_pkg::CMD_WEIGHT, a, $urandom_range(hi - lo) + lo);
    endtask

    task automatic test_full_load();
        // modest weights so the softmax sees a spread of logits
        run_small_rand(-600, 600, 0, DEPTH);
        for (int i = 0; i < NI; i++)
            send_beat(mrs_pkg::CMD_FEATURE, i, $urandom_range(8191) - 4096);
        send_beat(mrs_pkg::CMD_RUN, 0, 0);
        drain();
    endtask

    task automatic test_edges();
        send_beat(mrs_pkg::CMD_FEATURE, 0, -32768);
        send_beat(mrs_pkg::CMD_FEATURE, NI - 1, 32767);
        send_beat(mrs_pkg::CMD_FEATURE, NI, 1234);
        send_beat(mrs_pkg::CMD_FEATURE, 32767, -1);
        send_beat(mrs_pkg::CMD_WEIGHT, 0, 32767);
        send_beat(mrs_pkg::CMD_WEIGHT, DEPTH - 1, -32768);
        send_beat(mrs_pkg::CMD_WEIGHT, DEPTH, 777);
        send_beat(mrs_pkg::CMD_WEIGHT, 32767, -777);
        send_beat(mrs_pkg::CMD_RSVD, 21845, 21845);
        send_beat(mrs_pkg::CMD_RSVD, 10922, -21846);
        send_beat(mrs_pkg::CMD_RUN, 32767, -1);
        // one dominant class, the rest far below
        for (int i = 0; i < NO; i++)
            send_beat(mrs_pkg::CMD_WEIGHT, OFS_B3 + i, (i == 3) ? 32767 : -32768);
        send_beat(mrs_pkg::CMD_RUN, 0, 0);
        drain();
    endtask

    task automatic test_tied_logits();
        for (int a = OFS_W3; a < DEPTH; a++)
            send_beat(mrs_pkg::CMD_WEIGHT, a, 0);
        send_beat(mrs_pkg::CMD_RUN, 0, 0);
        drain();
        run_small_rand(-600, 600, OFS_W3, DEPTH - OFS_W3);
        send_beat(mrs_pkg::CMD_RUN, 0, 0);
        drain();
    endtask

    task automatic test_random(input int n);
        int sel;
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(99);
            if (sel < 10)
                send_beat(mrs_pkg::CMD_RUN, $urandom_range(32767), $urandom_range(65535));
            else if (sel < 45)
                send_beat(mrs_pkg::CMD_WEIGHT, $urandom_range(DEPTH - 1), $urandom_range(65535));
            else if (sel < 65)
                send_beat(mrs_pkg::CMD_WEIGHT, OFS_W3 + $urandom_range(DEPTH - OFS_W3 - 1),
                          $urandom_range(2000) - 1000);
            else if (sel < 70)
                send_beat(mrs_pkg::CMD_WEIGHT, $urandom_range(32767, DEPTH),
                          $urandom_range(65535));
            else if (sel < 88)
                send_beat(mrs_pkg::CMD_FEATURE, $urandom_range(NI - 1), $urandom_range(65535));
            else if (sel < 93)
                send_beat(mrs_pkg::CMD_FEATURE, $urandom_range(32767, NI),
                          $urandom_range(65535));
            else
                send_beat(mrs_pkg::CMD_RSVD, $urandom_range(32767), $urandom_range(65535));
        end
        send_beat(mrs_pkg::CMD_RUN, 0, 0);
        drain();
    endtask

    always @(posedge clk)
    begin
        prob_t exp_r;
        if (res_if.valid && res_if.ready)
        begin
            if (prob_q.size() == 0)
            begin
                $error("unexpected result beat: class %0d", res_if.class_index);
                errors++;
            end
            else
            begin
                exp_r = prob_q.pop_front();
                if (res_if.class_index !== exp_r.class_index)
                begin
                    $error("class_index: expected %0d, got %0d", exp_r.class_index,
                           res_if.class_index);
                    errors++;
                end
                if (res_if.probability !== exp_r.probability)
                begin
                    $error("probability: expected %0d, got %0d", exp_r.probability,
                           res_if.probability);
                    errors++;
                end
                if (res_if.last !== exp_r.last)
                begin
                    $error("last: expected %0d, got %0d", exp_r.last, res_if.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("mlp_relu_softmax_inference_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        item_if.valid <= 1'b0;
        item_if.cmd   <= mrs_pkg::CMD_WEIGHT;
        item_if.addr  <= '0;
        item_if.value <= '0;
        send_idle_pct = 18;
        recv_stall_pct = 83;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_full_load();
        test_edges();
        test_tied_logits();
        test_random(35);
        send_idle_pct = 83;
        recv_stall_pct = 18;
        test_random(35);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(35);
        if (prob_q.size() != 0)
        begin
            $error("%0d expected results never arrived", prob_q.size());
            errors++;
        end
        if (errors == 0)
            $display("mlp_relu_softmax_inference_test: PASS");
        else
            $display("mlp_relu_softmax_inference_test: FAIL");
        $finish;
    end
endmodule

[sim.f]
sv/mrs_pkg.sv
sv/mrs_if.sv
sv/mrs_ram.sv
sv/mrs_datapath.sv
sv/mrs_ctrl.sv
sv/mlp_relu_softmax_inference.sv
bench/mlp_relu_softmax_inference_test.sv
